// File: rtl/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

	// Header length codes and byte counts
	localparam logic [6:0] LenCode16  = 7'd126;
	localparam logic [6:0] LenCode64  = 7'd127;
	localparam logic [3:0] ExtBytes16 = 4'd2;
	localparam logic [3:0] ExtBytes64 = 4'd8;
	localparam logic [3:0] KeyBytes   = 4'd4;

	// One result item
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        frame_status;
		logic        frame_last;
		logic [63:0] frame_length;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/wsd_if.sv
`default_nettype none
// Input byte channel
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       buffer_end;

	modport source (output valid, output in_byte, output buffer_end, input ready);
	modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

// Result channel
interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        byte_valid;
	logic        frame_status;
	logic        frame_last;
	logic [63:0] frame_length;

	modport source (output valid, output payload_byte, output byte_valid,
		output frame_status, output frame_last, output frame_length, input ready);
	modport sink (input valid, input payload_byte, input byte_valid,
		input frame_status, input frame_last, input frame_length, output ready);
endinterface
`default_nettype wire

// File: rtl/wsd_parse.sv
`default_nettype none
module wsd_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire logic          buffer_end,
	output wsd_pkg::res_t      res,
	output logic               push
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        mask_q, mask_d;
	logic [3:0]  hcnt_q, hcnt_d;
	logic [63:0] len_q, len_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [7:0]  key_q [4];
	logic        key_we;
	logic        go_lk, go_bp, done, pvalid;
	logic [7:0]  pb;

	// Next-state and result logic for one accepted byte
	always_comb begin
		phase_d = phase_q;
		mask_d  = mask_q;
		hcnt_d  = hcnt_q;
		len_d   = len_q;
		rem_d   = rem_q;
		kidx_d  = kidx_q;
		key_we  = 1'b0;
		go_lk   = 1'b0;
		go_bp   = 1'b0;
		done    = 1'b0;
		pvalid  = 1'b0;
		pb      = 8'd0;

		case (phase_q)
			PH_HDR0: begin
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = in_byte[7];
				len_d  = '0;
				if (in_byte[6:0] == LenCode16) begin
					hcnt_d  = ExtBytes16;
					phase_d = PH_EXT;
				end else if (in_byte[6:0] == LenCode64) begin
					hcnt_d  = ExtBytes64;
					phase_d = PH_EXT;
				end else begin
					len_d = {57'd0, in_byte[6:0]};
					go_lk = 1'b1;
				end
			end
			PH_EXT: begin
				len_d  = {len_q[55:0], in_byte};
				hcnt_d = hcnt_q - 4'd1;
				go_lk  = (hcnt_q == 4'd1);
			end
			PH_KEY: begin
				key_we = 1'b1;
				hcnt_d = hcnt_q + 4'd1;
				go_bp  = (hcnt_q == KeyBytes - 4'd1);
			end
			PH_PAYLOAD: begin
				pb     = mask_q ? (in_byte ^ key_q[kidx_q]) : in_byte;
				kidx_d = kidx_q + 2'd1;
				pvalid = 1'b1;
				rem_d  = rem_q - 64'd1;
				if (rem_q == 64'd1) begin
					phase_d = PH_DONE;
					done    = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Length known: collect the key, or go straight to the payload
		if (go_lk) begin
			if (mask_d) begin
				phase_d = PH_KEY;
				hcnt_d  = 4'd0;
			end else begin
				go_bp = 1'b1;
			end
		end

		// Payload start; an empty payload completes the frame here
		if (go_bp) begin
			rem_d  = len_d;
			kidx_d = 2'd0;
			if (len_d == 64'd0) begin
				phase_d = PH_DONE;
				done    = 1'b1;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end
	end

	// Result item; completion wins over an early buffer end
	always_comb begin
		res.payload_byte = pb;
		res.byte_valid   = pvalid;
		res.frame_status = 1'b0;
		res.frame_last   = 1'b0;
		res.frame_length = '0;
		if (done) begin
			res.frame_last   = 1'b1;
			res.frame_length = len_d;
		end else if (buffer_end && phase_q != PH_DONE) begin
			res.frame_last   = 1'b1;
			res.frame_status = 1'b1;
		end
		push = accept && (pvalid || res.frame_last);
	end

	// Parser state; the end of a buffer returns it to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			mask_q  <= 1'b0;
			hcnt_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			kidx_q  <= '0;
		end else if (accept) begin
			if (buffer_end) begin
				phase_q <= PH_HDR0;
				mask_q  <= 1'b0;
				hcnt_q  <= '0;
				len_q   <= '0;
				rem_q   <= '0;
				kidx_q  <= '0;
			end else begin
				phase_q <= phase_d;
				mask_q  <= mask_d;
				hcnt_q  <= hcnt_d;
				len_q   <= len_d;
				rem_q   <= rem_d;
				kidx_q  <= kidx_d;
			end
		end
	end

	// Mask key bytes; only read after all four are written in this buffer
	always_ff @(posedge clk) begin
		if (accept && key_we) begin
			key_q[hcnt_q[1:0]] <= in_byte;
		end
	end

endmodule
`default_nettype wire

// File: rtl/wsd_outbuf.sv
`default_nettype none
module wsd_outbuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire wsd_pkg::res_t push_data,
	output logic               space,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wsd_pkg::res_t      out_data
);
	import wsd_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves without reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q  <= skid_valid_q ? skid_q : push_data;
			skid_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/websocket_frame_deframer_core.sv
// A result item is registered in the output stage before it appears on res.
// Throughput: one byte accepted per cycle while the output stage has space.
// A two-entry output stage (register plus skid) keeps input flowing while
// a result waits; input stalls only when both entries are full.
// Reset (arst_n low, asynchronous): parser expects the first header byte and
// the output stage is empty.
`default_nettype none
module websocket_frame_deframer_core (
	input  wire logic clk,
	input  wire logic arst_n,
	wsd_in_if.sink    inp,
	wsd_out_if.source res
);
	import wsd_pkg::*;

	logic accept, push, space, out_valid;
	res_t push_data, out_data;

	assign inp.ready = space;
	assign accept    = inp.valid && space;

	// Header parse, demask and frame status
	wsd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (inp.in_byte),
		.buffer_end (inp.buffer_end),
		.res        (push_data),
		.push       (push)
	);

	// Result register and skid
	wsd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);

	assign res.valid        = out_valid;
	assign res.payload_byte = out_data.payload_byte;
	assign res.byte_valid   = out_data.byte_valid;
	assign res.frame_status = out_data.frame_status;
	assign res.frame_last   = out_data.frame_last;
	assign res.frame_length = out_data.frame_length;

endmodule
`default_nettype wire

// File: bench/websocket_frame_deframer_core_tb.sv
module websocket_frame_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	// Parser phases of the predictor
	typedef enum logic [2:0] {
		PhHdr0,
		PhHdr1,
		PhExt,
		PhKey,
		PhPayload,
		PhDone
	} phase_t;

	logic clk;
	logic arst_n;

	wsd_in_if  in_ch ();
	wsd_out_if res_ch ();

	websocket_frame_deframer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (in_ch),
		.res    (res_ch)
	);

	// Predictor state
	phase_t      phase;
	logic        mask_on;
	logic [3:0]  hdr_count;
	logic [63:0] declared_len;
	logic [63:0] remaining;
	logic [7:0]  pred_key [4];
	logic [1:0]  key_idx;

	res_t        pending_results [$];
	logic [7:0]  frame_bytes [$];
	int          mismatch_count = 0;
	int          sent_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("websocket_frame_deframer_core_tb: FAIL");
		$finish;
	end

	function automatic void clear_parser();
		phase = PhHdr0;
		mask_on = 1'b0;
		hdr_count = '0;
		declared_len = '0;
		remaining = '0;
		foreach (pred_key[i]) pred_key[i] = '0;
		key_idx = '0;
	endfunction

	// Enter the payload; 1 when the frame is already complete
	function automatic logic start_payload();
		remaining = declared_len;
		key_idx = '0;
		if (remaining == 0) begin
			phase = PhDone;
			return 1'b1;
		end
		phase = PhPayload;
		return 1'b0;
	endfunction

	function automatic logic length_known();
		if (mask_on) begin
			phase = PhKey;
			hdr_count = '0;
			return 1'b0;
		end
		return start_payload();
	endfunction

	// Advance the parser by one byte; returns 1 when the byte yields a result
	function automatic logic deframe_byte(input logic [7:0] b, input logic eob,
		output res_t r);
		phase_t     prev;
		logic       done;
		logic       valid;
		logic [7:0] pb;
		prev = phase;
		done = 1'b0;
		valid = 1'b0;
		pb = '0;
		case (phase)
			PhHdr0: begin
				phase = PhHdr1;
			end
			PhHdr1: begin
				mask_on = b[7];
				declared_len = '0;
				if (b[6:0] == LenCode16) begin
					hdr_count = ExtBytes16;
					phase = PhExt;
				end else if (b[6:0] == LenCode64) begin
					hdr_count = ExtBytes64;
					phase = PhExt;
				end else begin
					declared_len = {57'd0, b[6:0]};
					done = length_known();
				end
			end
			PhExt: begin
				declared_len = {declared_len[55:0], b};
				hdr_count = hdr_count - 4'd1;
				if (hdr_count == 0) done = length_known();
			end
			PhKey: begin
				pred_key[hdr_count[1:0]] = b;
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= KeyBytes) done = start_payload();
			end
			PhPayload: begin
				pb = mask_on ? (b ^ pred_key[key_idx]) : b;
				key_idx = key_idx + 2'd1;
				valid = 1'b1;
				remaining = remaining - 64'd1;
				if (remaining == 0) begin
					phase = PhDone;
					done = 1'b1;
				end
			end
			default: ;
		endcase

		r = '0;
		r.payload_byte = pb;
		r.byte_valid = valid;
		// completion wins over an early buffer end
		if (done) begin
			r.frame_last = 1'b1;
			r.frame_length = declared_len;
		end else if (eob && prev != PhDone) begin
			r.frame_last = 1'b1;
			r.frame_status = 1'b1;
		end
		if (eob) clear_parser();
		return valid || r.frame_last;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	// Check results against the oldest expectation, then predict from accepted bytes
	always @(posedge clk) begin
		res_t got;
		res_t want;
		res_t pred;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '0;
				got.payload_byte = res_ch.payload_byte;
				got.byte_valid = res_ch.byte_valid;
				got.frame_status = res_ch.frame_status;
				got.frame_last = res_ch.frame_last;
				got.frame_length = res_ch.frame_length;
				if (pending_results.size() == 0) begin
					flag_mismatch("unexpected item, last/status", 64'd0,
						{62'd0, got.frame_last, got.frame_status});
				end else begin
					want = pending_results.pop_front();
					if (got.payload_byte !== want.payload_byte)
						flag_mismatch("payload_byte", want.payload_byte, got.payload_byte);
					if (got.byte_valid !== want.byte_valid)
						flag_mismatch("byte_valid", want.byte_valid, got.byte_valid);
					if (got.frame_status !== want.frame_status)
						flag_mismatch("frame_status", want.frame_status, got.frame_status);
					if (got.frame_last !== want.frame_last)
						flag_mismatch("frame_last", want.frame_last, got.frame_last);
					if (got.frame_length !== want.frame_length)
						flag_mismatch("frame_length", want.frame_length, got.frame_length);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (deframe_byte(in_ch.in_byte, in_ch.buffer_end, pred))
					pending_results.push_back(pred);
			end
		end
	end

	// Result side: long hold-off when requested, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one byte, with random gaps, and wait until it is taken
	task automatic send_byte(input logic [7:0] b, input logic eob);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.in_byte <= 8'($urandom);
			in_ch.buffer_end <= 1'($urandom);
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.buffer_end <= eob;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	// Send frame_bytes as one buffer, end mark on its last byte
	task automatic send_buffer();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Random buffer: mostly well-formed frames, some cut short, some noise
	task automatic make_random_buffer();
		int          sel;
		int          pay_n;
		int          cut;
		logic        mask;
		logic [6:0]  code;
		logic [63:0] len;
		frame_bytes.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
			return;
		end
		frame_bytes.push_back(8'($urandom));
		mask = 1'($urandom);
		sel = $urandom_range(99);
		if (sel < 50) begin
			code = 7'($urandom_range(0, 12));
			len = 64'(code);
		end else if (sel < 62) begin
			code = 7'($urandom_range(13, 125));
			len = 64'(code);
		end else if (sel < 80) begin
			code = LenCode16;
			len = ($urandom_range(9) == 0) ? 64'($urandom_range(16'hFFFF))
				: 64'($urandom_range(0, 24));
		end else begin
			code = LenCode64;
			len = ($urandom_range(7) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, 24));
		end
		frame_bytes.push_back({mask, code});
		if (code == LenCode16) begin
			frame_bytes.push_back(len[15:8]);
			frame_bytes.push_back(len[7:0]);
		end else if (code == LenCode64) begin
			for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[i*8 +: 8]);
		end
		if (mask) repeat (4) frame_bytes.push_back(8'($urandom));
		// huge lengths: only a few payload bytes, the buffer ends early
		pay_n = (len > 200) ? $urandom_range(0, 6) : int'(len);
		repeat (pay_n) frame_bytes.push_back(8'($urandom));
		if (64'(pay_n) == len)
			repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
		if ($urandom_range(99) < 12 && frame_bytes.size() > 1) begin
			cut = $urandom_range(1, frame_bytes.size() - 1);
			frame_bytes = frame_bytes[0:cut-1];
		end
	endtask

	// Buffer of one byte ends inside the header
	task automatic test_truncated_header();
		frame_bytes = '{8'hFF};
		send_buffer();
	endtask

	// Zero-length payload completes on the header
	task automatic test_empty_payload();
		frame_bytes = '{8'h00, 8'h00};
		send_buffer();
	endtask

	// Masked payload, completion on the buffer's last byte
	task automatic test_masked_payload();
		frame_bytes = '{8'h81, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF};
		send_buffer();
	endtask

	// 16-bit length, then a trailing byte that carries the end mark
	task automatic test_ext16_trailing();
		frame_bytes = '{8'h82, 8'h7E, 8'h00, 8'h01, 8'h33, 8'hEE};
		send_buffer();
	endtask

	// 64-bit length with top bit set; buffer ends on a payload byte
	task automatic test_ext64_huge();
		frame_bytes = '{8'h02, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h01, 8'hAB};
		send_buffer();
	endtask

	task automatic test_random_frames(input int s_pct, input int r_pct, input int n_items);
		int start;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = sent_count;
		while (sent_count - start < n_items) begin
			make_random_buffer();
			send_buffer();
		end
	endtask

	// Receiver holds off while a long masked frame streams in
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		frame_bytes = '{8'h82, {1'b1, 7'd100}};
		repeat (4) frame_bytes.push_back(8'($urandom));
		repeat (100) frame_bytes.push_back(8'($urandom));
		hold_cycles = 200;
		send_buffer();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.buffer_end = 1'b0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		clear_parser();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_truncated_header();
		test_empty_payload();
		test_masked_payload();
		test_ext16_trailing();
		test_ext64_huge();
		test_random_frames(15, 62, 520);
		test_backpressure();
		test_random_frames(62, 15, 520);
		test_random_frames(0, 0, 520);

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("websocket_frame_deframer_core_tb: PASS");
		end else begin
			$display("websocket_frame_deframer_core_tb: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/wsd_parse.sv
rtl/wsd_outbuf.sv
rtl/websocket_frame_deframer_core.sv
bench/websocket_frame_deframer_core_tb.sv
